>>> rtl/zcid_pkg.sv
package zcid_pkg;

  // Knot table depth and address width
  localparam int MAX_KNOTS = 64;
  localparam int KAW = $clog2(MAX_KNOTS);

  // Request kinds carried on s_tuser
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_MODE  = 2'd0;
  localparam logic [1:0] CFG_FLAT  = 2'd1;
  localparam logic [1:0] CFG_COUNT = 2'd2;

  // ln2 in Q.47, rounded, and the offset 40*ln2 that keeps the reduced exponent positive
  localparam logic [51:0] LN2_Q47 = 52'h0_58B9_0BFB_E8E8;
  localparam logic [51:0] LN2_X40 = LN2_Q47 * 52'd40;

  // Exponent limits in Q.47: saturate at 2.0, flush to zero below -24.0
  localparam logic signed [57:0] E_SAT_LIM  = 58'sh0_0001_0000_0000_0000;
  localparam logic signed [57:0] E_ZERO_LIM = -58'sh0_000C_0000_0000_0000;

  // Number of Taylor terms after the constant one
  localparam logic [4:0] TAYLOR_TERMS = 5'd20;

  // Exponential unit request and result
  typedef struct packed {
    logic               start;
    logic signed [31:0] rate;
    logic        [23:0] qtime;
  } exp_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] df;
    logic        sat;
  } exp_res_t;

endpackage

>>> rtl/zcid_exp.sv
module zcid_exp import zcid_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  exp_req_t req,
  output exp_res_t res
);

  typedef enum logic [9:0] {
    E_IDLE  = 10'b0000000001,
    E_MUL   = 10'b0000000010,
    E_RANGE = 10'b0000000100,
    E_QDIV  = 10'b0000001000,
    E_TMUL  = 10'b0000010000,
    E_TLOAD = 10'b0000100000,
    E_TDIV  = 10'b0001000000,
    E_TACC  = 10'b0010000000,
    E_FIN1  = 10'b0100000000,
    E_FIN2  = 10'b1000000000
  } exp_state_t;

  exp_state_t state;

  logic signed [31:0]  rate_r;
  logic        [23:0]  time_r;
  logic signed [56:0]  prod;
  logic signed [57:0]  e;
  logic        [51:0]  u;
  logic        [51:0]  u_trial;
  logic        [51:0]  u_sub;
  logic                u_ge;
  logic        [5:0]   qk;
  logic        [2:0]   qbit;
  logic        [61:0]  r62;
  logic        [62:0]  term;
  logic        [63:0]  sum;
  logic        [124:0] acc;
  logic        [1:0]   mcnt;
  logic        [31:0]  pa;
  logic        [31:0]  pb;
  logic        [63:0]  pp;
  logic        [124:0] pp_sh;
  logic        [63:0]  dq;
  logic        [4:0]   drem;
  logic        [2:0]   dcnt;
  logic        [4:0]   drem_next;
  logic        [7:0]   dqb;
  logic        [4:0]   tn;
  logic        [6:0]   fin_sh;
  logic        [5:0]   sh;
  logic        [63:0]  rsum;
  logic        [63:0]  df64;
  logic        [31:0]  df;
  logic                sat;
  logic                done;

  // Exponent product and range reduction step
  assign prod    = rate_r * $signed({1'b0, time_r});
  assign u_trial = LN2_Q47 << qbit;
  assign u_ge    = (u >= u_trial);
  assign u_sub   = u_ge ? (u - u_trial) : u;

  // Partial product of the term times the reduced argument
  always_comb begin
    pa = mcnt[0] ? {1'b0, term[62:32]} : term[31:0];
    pb = mcnt[1] ? {2'b0, r62[61:32]} : r62[31:0];
    pp = pa * pb;
    case (mcnt)
      2'd0:    pp_sh = {61'b0, pp};
      2'd3:    pp_sh = {61'b0, pp} << 64;
      default: pp_sh = {61'b0, pp} << 32;
    endcase
  end

  // Eight restoring steps of the division by the term number
  always_comb begin
    logic [5:0] tr;
    logic [4:0] r;
    r   = drem;
    dqb = 8'b0;
    for (int j = 0; j < 8; j++) begin
      tr = {r, dq[63-j]};
      if (tr >= {1'b0, tn}) begin
        r        = 5'(tr - {1'b0, tn});
        dqb[7-j] = 1'b1;
      end else begin
        r = tr[4:0];
      end
    end
    drem_next = r;
  end

  // Final scale by 2^k with rounding
  assign fin_sh = 7'd72 - {1'b0, qk};
  assign df64   = rsum >> sh;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        E_IDLE: begin
          if (req.start) begin
            rate_r <= req.rate;
            time_r <= req.qtime;
            state  <= E_MUL;
          end
        end
        E_MUL: begin
          e     <= 58'sd0 - 58'(prod);
          state <= E_RANGE;
        end
        E_RANGE: begin
          if (e >= E_SAT_LIM) begin
            df    <= 32'hFFFF_FFFF;
            sat   <= 1'b1;
            done  <= 1'b1;
            state <= E_IDLE;
          end else if (e < E_ZERO_LIM) begin
            df    <= 32'h0;
            sat   <= 1'b0;
            done  <= 1'b1;
            state <= E_IDLE;
          end else begin
            u     <= e[51:0] + LN2_X40;
            qk    <= 6'd0;
            qbit  <= 3'd5;
            state <= E_QDIV;
          end
        end
        E_QDIV: begin
          u        <= u_sub;
          qk[qbit] <= u_ge;
          if (qbit == 3'd0) begin
            r62   <= {u_sub[46:0], 15'b0};
            term  <= {1'b1, 62'b0};
            sum   <= {2'b01, 62'b0};
            tn    <= 5'd1;
            acc   <= '0;
            mcnt  <= 2'd0;
            state <= E_TMUL;
          end else begin
            qbit <= qbit - 3'd1;
          end
        end
        E_TMUL: begin
          acc  <= acc + pp_sh;
          mcnt <= mcnt + 2'd1;
          if (mcnt == 2'd3) begin
            state <= E_TLOAD;
          end
        end
        E_TLOAD: begin
          dq    <= {1'b0, acc[124:62]};
          drem  <= 5'd0;
          dcnt  <= 3'd0;
          state <= E_TDIV;
        end
        E_TDIV: begin
          dq   <= {dq[55:0], dqb};
          drem <= drem_next;
          dcnt <= dcnt + 3'd1;
          if (dcnt == 3'd7) begin
            state <= E_TACC;
          end
        end
        E_TACC: begin
          term <= dq[62:0];
          sum  <= sum + dq;
          if (tn == TAYLOR_TERMS) begin
            state <= E_FIN1;
          end else begin
            tn    <= tn + 5'd1;
            acc   <= '0;
            mcnt  <= 2'd0;
            state <= E_TMUL;
          end
        end
        E_FIN1: begin
          if (fin_sh >= 7'd64) begin
            df    <= 32'h0;
            sat   <= 1'b0;
            done  <= 1'b1;
            state <= E_IDLE;
          end else begin
            sh    <= fin_sh[5:0];
            rsum  <= sum + (64'd1 << (fin_sh[5:0] - 6'd1));
            state <= E_FIN2;
          end
        end
        E_FIN2: begin
          if (df64[63:32] != 32'h0) begin
            df  <= 32'hFFFF_FFFF;
            sat <= 1'b1;
          end else begin
            df  <= df64[31:0];
            sat <= 1'b0;
          end
          done  <= 1'b1;
          state <= E_IDLE;
        end
        default: state <= E_IDLE;
      endcase
    end
  end

  assign res.done = done;
  assign res.df   = df;
  assign res.sat  = sat;

`ifndef SYNTHESIS
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == E_TDIV) |-> (drem < tn)) else $error("term division remainder too large");
  a_term_number_range: assert property (@(posedge clk) disable iff (rst)
    (state == E_TDIV) |-> (tn >= 5'd1 && tn <= TAYLOR_TERMS))
    else $error("term number out of range");
  a_ln2_multiple_range: assert property (@(posedge clk) disable iff (rst)
    (state == E_FIN1) |-> (qk <= 6'd42)) else $error("ln2 multiple out of range");
`endif

endmodule

>>> rtl/zero_curve_interp_discount_unit.sv
// Channel   Dir  Handshake               Payload
// s_*       in   s_tvalid / s_tready     s_tuser req_type, s_tdata knot and query fields
// m_*       out  m_tvalid / m_tready     m_tuser saturated, m_tdata rate and discount
// cfg_*     in   cfg_valid / cfg_ready   cfg_index register, cfg_data value
//
// A knot write is taken in the idle state and leaves it idle. A query in flat mode or when
// the time is at or beyond a table end goes to the exponential without interpolation; when
// it interpolates, the knot scan reads one table entry per wait state and compare state, the
// weight comes from a one-bit-per-cycle divider, and the exponential runs 20 Taylor terms
// on one 32x32 multiplier (four passes each) and an eight-bit-per-cycle divider.
// Reset (rst, synchronous) sets curve_mode 1, flat_rate 0, knot_count 1; the table is
// not cleared. s_tready is low while a query is in flight; a finished result waits in
// the output register while the next item is taken. cfg_ready is always high.
module zero_curve_interp_discount_unit import zcid_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,   // knot_index[5:0], knot_time[29:6], knot_rate[61:30],
                                 // query_time[85:62], zero[87:86]
  input  logic        s_tuser,   // req_type[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // rate_out[31:0], discount_factor[63:32]
  output logic        m_tuser,   // saturated[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef enum logic [11:0] {
    T_IDLE = 12'b000000000001,
    T_W0   = 12'b000000000010,
    T_C0   = 12'b000000000100,
    T_W1   = 12'b000000001000,
    T_C1   = 12'b000000010000,
    T_WS   = 12'b000000100000,
    T_CS   = 12'b000001000000,
    T_MUL  = 12'b000010000000,
    T_DIV  = 12'b000100000000,
    T_ADJ  = 12'b001000000000,
    T_EXP  = 12'b010000000000,
    T_OUT  = 12'b100000000000
  } top_state_t;

  top_state_t state;

  logic        curve_mode;
  logic [31:0] flat_rate;
  logic [6:0]  knot_count;

  logic [23:0] knot_times_mem [MAX_KNOTS];
  logic [31:0] knot_rates_mem [MAX_KNOTS];
  logic [KAW-1:0] raddr;
  logic [23:0] rd_t;
  logic [31:0] rd_r;

  logic [5:0]     wr_idx;
  logic [KAW-1:0] nl;
  logic [KAW-1:0] nlast;
  logic [KAW-1:0] scan_i;
  logic [23:0]    qtime;
  logic [23:0]    lo_t;
  logic [31:0]    lo_r;
  logic [23:0]    hi_t;
  logic [31:0]    hi_r;
  logic [31:0]    rate_sel;

  logic [23:0]        num;
  logic [23:0]        den;
  logic signed [32:0] diff;
  logic [32:0]        mag;
  logic [56:0]        iprod;
  logic [57:0]        dq58;
  logic [24:0]        irem;
  logic [24:0]        idiv;
  logic [5:0]         icnt;
  logic               diff_neg;
  logic [25:0]        itrial;
  logic               ige;

  logic     exp_start;
  exp_req_t exp_req;
  exp_res_t exp_res;
  logic     out_load;

  assign s_tready  = (state == T_IDLE);
  assign cfg_ready = 1'b1;
  assign wr_idx    = s_tdata[5:0];

  // Clamp the knot count to the table and take the last index
  always_comb begin
    if (knot_count == 7'd0) begin
      nl = '0;
    end else if (32'(knot_count) > MAX_KNOTS) begin
      nl = KAW'(MAX_KNOTS - 1);
    end else begin
      nl = KAW'(knot_count - 7'd1);
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      curve_mode <= 1'b1;
      flat_rate  <= 32'h0;
      knot_count <= 7'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MODE:  curve_mode <= cfg_data[0];
        CFG_FLAT:  flat_rate  <= cfg_data;
        CFG_COUNT: knot_count <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Knot table: write on a knot transaction, registered read
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready && (s_tuser == REQ_WRITE) && (32'(wr_idx) < MAX_KNOTS)) begin
      knot_times_mem[KAW'(wr_idx)] <= s_tdata[29:6];
      knot_rates_mem[KAW'(wr_idx)] <= s_tdata[61:30];
    end
    rd_t <= knot_times_mem[raddr];
    rd_r <= knot_rates_mem[raddr];
  end

  // Interpolation operands and divider step
  assign num    = qtime - lo_t;
  assign den    = hi_t - lo_t;
  assign diff   = $signed({hi_r[31], hi_r}) - $signed({lo_r[31], lo_r});
  assign mag    = diff[32] ? 33'(-diff) : 33'(diff);
  assign iprod  = mag * num;
  assign itrial = {irem, dq58[57]};
  assign ige    = (itrial >= {1'b0, idiv});

  // Query sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      exp_start <= 1'b0;
    end else begin
      exp_start <= 1'b0;
      case (state)
        T_IDLE: begin
          if (s_tvalid && (s_tuser == REQ_QUERY)) begin
            qtime <= s_tdata[85:62];
            if (!curve_mode) begin
              rate_sel  <= flat_rate;
              exp_start <= 1'b1;
              state     <= T_EXP;
            end else begin
              raddr <= '0;
              nlast <= nl;
              state <= T_W0;
            end
          end
        end
        T_W0: state <= T_C0;
        T_C0: begin
          lo_t <= rd_t;
          lo_r <= rd_r;
          if (qtime <= rd_t) begin
            rate_sel  <= rd_r;
            exp_start <= 1'b1;
            state     <= T_EXP;
          end else begin
            raddr <= nlast;
            state <= T_W1;
          end
        end
        T_W1: state <= T_C1;
        T_C1: begin
          if (qtime >= rd_t) begin
            rate_sel  <= rd_r;
            exp_start <= 1'b1;
            state     <= T_EXP;
          end else begin
            raddr  <= KAW'(1);
            scan_i <= KAW'(1);
            state  <= T_WS;
          end
        end
        T_WS: state <= T_CS;
        T_CS: begin
          if ((scan_i < nlast) && (rd_t <= qtime)) begin
            lo_t   <= rd_t;
            lo_r   <= rd_r;
            scan_i <= scan_i + KAW'(1);
            raddr  <= scan_i + KAW'(1);
            state  <= T_WS;
          end else begin
            hi_t  <= rd_t;
            hi_r  <= rd_r;
            state <= T_MUL;
          end
        end
        T_MUL: begin
          dq58     <= {iprod, 1'b0} + {34'b0, den};
          idiv     <= {den, 1'b0};
          diff_neg <= diff[32];
          irem     <= 25'd0;
          icnt     <= 6'd0;
          state    <= T_DIV;
        end
        T_DIV: begin
          irem <= ige ? 25'(itrial - {1'b0, idiv}) : itrial[24:0];
          dq58 <= {dq58[56:0], ige};
          icnt <= icnt + 6'd1;
          if (icnt == 6'd57) begin
            state <= T_ADJ;
          end
        end
        T_ADJ: begin
          rate_sel  <= diff_neg ? (lo_r - dq58[31:0]) : (lo_r + dq58[31:0]);
          exp_start <= 1'b1;
          state     <= T_EXP;
        end
        T_EXP: begin
          if (exp_res.done) begin
            state <= T_OUT;
          end
        end
        T_OUT: begin
          if (out_load) begin
            state <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  assign exp_req.start = exp_start;
  assign exp_req.rate  = $signed(rate_sel);
  assign exp_req.qtime = qtime;

  zcid_exp u_exp (
    .clk (clk),
    .rst (rst),
    .req (exp_req),
    .res (exp_res)
  );

  // Output register: load when empty or being drained
  assign out_load = (state == T_OUT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {exp_res.df, rate_sel};
      m_tuser <= exp_res.sat;
    end
  end

`ifndef SYNTHESIS
  a_scan_in_table: assert property (@(posedge clk) disable iff (rst)
    (state == T_CS) |-> (scan_i <= nlast)) else $error("knot scan past last knot");
  a_weight_fits: assert property (@(posedge clk) disable iff (rst)
    (state == T_ADJ) |-> (dq58[57:33] == 25'd0)) else $error("interpolation step too large");
  a_exp_done_owned: assert property (@(posedge clk) disable iff (rst)
    exp_res.done |-> (state == T_EXP)) else $error("exponential result without a query");
`endif

endmodule
